// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/dss_pkg.sv
// ---------------------------------------------------------------------------
// dss_pkg
// Types, codes and defaults shared by the dual stack blocks.
// ---------------------------------------------------------------------------
package dss_pkg;

  localparam int DEF_STORE_DEPTH = 256;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int IN_VALUE_W = 32;
  localparam int CFG_W      = 9;
  localparam int DEPTH_W    = 9;
  localparam int STATUS_W   = 2;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STAT_DONE      = 2'd0;
  localparam status_t STAT_OVERFLOW  = 2'd1;
  localparam status_t STAT_UNDERFLOW = 2'd2;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_POP   = 1'b1;
  localparam logic SEL_LOWER = 1'b0;
  localparam logic SEL_UPPER = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic exec;      // beat accepted: evaluate and update this cycle
    logic cfg_load;  // load capacity register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;     // both stacks hold nothing
  } stat_t;

endpackage

// File: hdl/dss_ctrl.sv
// ---------------------------------------------------------------------------
// dss_ctrl
// Two-state sequencer: accepts a command beat, then presents its result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          cfg_we,
  input  dss_pkg::stat_t stat,
  output logic          busy,
  output logic          out_strobe,
  output dss_pkg::cmd_t cmd
);
  import dss_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RESP = 1'b1;

  logic state_r, state_nxt;
  logic accept;

  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy         = (state_r == ST_RESP);
  assign out_strobe   = (state_r == ST_RESP);
  assign cmd.exec     = accept;
  // capacity changes only while both stacks are empty
  assign cmd.cfg_load = cfg_we && stat.empty;

  `ASSERT_NEXT(a_strobe_follows_accept, accept, out_strobe, "no result after accepted beat")
  `ASSERT_NEXT(a_single_strobe, out_strobe, !out_strobe, "result shown twice")

endmodule

// File: hdl/dss_datapath.sv
// ---------------------------------------------------------------------------
// dss_datapath
// Stack pointers, capacity register, shared entry memory and result regs.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dss_datapath #(
  parameter int STORE_DEPTH = dss_pkg::DEF_STORE_DEPTH,
  parameter int VALUE_WIDTH = dss_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dss_pkg::cmd_t                         cmd,
  input  logic                                  in_action,
  input  logic                                  in_stack_select,
  input  logic signed [dss_pkg::IN_VALUE_W-1:0] in_push_value,
  input  logic        [dss_pkg::CFG_W-1:0]      cfg_wdata,
  output dss_pkg::stat_t                        stat,
  output logic        [dss_pkg::STATUS_W-1:0]   out_status,
  output logic signed [dss_pkg::IN_VALUE_W-1:0] out_popped_value,
  output logic        [dss_pkg::DEPTH_W-1:0]    out_depth_lower,
  output logic        [dss_pkg::DEPTH_W-1:0]    out_depth_upper
);
  import dss_pkg::*;

  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int WIDE_W = 64;

  logic [CNT_W-1:0] lower_r, lower_nxt;
  logic [CNT_W-1:0] upper_r, upper_nxt;
  logic [CNT_W-1:0] cap_r, cap_nxt;
  status_t          status_r, status_nxt;
  logic             pop_ok_r, pop_ok_nxt;

  logic [VALUE_WIDTH-1:0] mem [STORE_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_r;
  logic                   we, re;
  logic [CNT_W-1:0]       slot;
  logic [ADDR_W-1:0]      addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [WIDE_W-1:0]      push_ext;
  logic [WIDE_W-1:0]      rd_ext;
  logic [CNT_W:0]         fill;
  logic                   full;
  logic [CMP_W-1:0]       cfg_v;

  assign push_ext = WIDE_W'(in_push_value);
  assign wr_data  = push_ext[VALUE_WIDTH-1:0];
  assign fill     = {1'b0, lower_r} + {1'b0, upper_r};
  assign full     = fill >= {1'b0, cap_r};
  assign addr     = slot[ADDR_W-1:0];

  // capacity clamp into [1, STORE_DEPTH]
  always_comb begin
    cfg_v = CMP_W'(cfg_wdata);
    if (cfg_v == '0) cfg_v = CMP_W'(1);
    if (cfg_v > CMP_W'(STORE_DEPTH)) cfg_v = CMP_W'(STORE_DEPTH);
    cap_nxt = cmd.cfg_load ? CNT_W'(cfg_v) : cap_r;
  end

  always_comb begin
    lower_nxt  = lower_r;
    upper_nxt  = upper_r;
    status_nxt = status_r;
    pop_ok_nxt = pop_ok_r;
    we         = 1'b0;
    re         = 1'b0;
    slot       = '0;
    if (cmd.exec) begin
      status_nxt = STAT_DONE;
      pop_ok_nxt = 1'b0;
      if (in_action == ACT_PUSH) begin
        if (full) begin
          status_nxt = STAT_OVERFLOW;
        end else if (in_stack_select == SEL_LOWER) begin
          slot      = lower_r;
          we        = 1'b1;
          lower_nxt = lower_r + CNT_W'(1);
        end else begin
          slot      = cap_r - CNT_W'(1) - upper_r;
          we        = 1'b1;
          upper_nxt = upper_r + CNT_W'(1);
        end
      end else begin
        if (in_stack_select == SEL_LOWER) begin
          if (lower_r == '0) begin
            status_nxt = STAT_UNDERFLOW;
          end else begin
            lower_nxt  = lower_r - CNT_W'(1);
            slot       = lower_r - CNT_W'(1);
            re         = 1'b1;
            pop_ok_nxt = 1'b1;
          end
        end else begin
          if (upper_r == '0) begin
            status_nxt = STAT_UNDERFLOW;
          end else begin
            upper_nxt  = upper_r - CNT_W'(1);
            slot       = cap_r - upper_r;
            re         = 1'b1;
            pop_ok_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r  <= '0;
      upper_r  <= '0;
      cap_r    <= CNT_W'(STORE_DEPTH);
      status_r <= STAT_DONE;
      pop_ok_r <= 1'b0;
    end else begin
      lower_r  <= lower_nxt;
      upper_r  <= upper_nxt;
      cap_r    <= cap_nxt;
      status_r <= status_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (re) rd_r <= mem[addr];
  end

  assign rd_ext           = WIDE_W'(rd_r);
  assign stat.empty       = (lower_r == '0) && (upper_r == '0);
  assign out_status       = status_r;
  assign out_popped_value = pop_ok_r ? rd_ext[IN_VALUE_W-1:0] : '0;
  assign out_depth_lower  = DEPTH_W'(lower_r);
  assign out_depth_upper  = DEPTH_W'(upper_r);

  `ASSERT_ALWAYS(a_fill_bound, fill <= {1'b0, cap_r}, "stacks overlap past capacity")
  `ASSERT_NEXT(a_refused_holds, cmd.exec && (status_nxt != STAT_DONE), $stable(lower_r) && $stable(upper_r), "refused op moved a pointer")
  `ASSERT_ALWAYS(a_pop_ok_done, !pop_ok_r || (status_r == STAT_DONE), "popped value on failed op")

endmodule

// File: hdl/dual_stack_shared_store.sv
// ---------------------------------------------------------------------------
// dual_stack_shared_store
// Two stacks sharing one entry memory: lower stack grows up from entry 0,
// upper stack grows down from entry capacity-1.
// ---------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  input    | start, busy (start&!busy) | in_action, in_stack_select,
//           |                           | in_push_value
//  result   | out_strobe (1 cycle)      | out_status, out_popped_value,
//           |                           | out_depth_lower, out_depth_upper
//  config   | cfg_we                    | cfg_wdata (capacity)
//
//  Sequence: each beat is evaluated and accesses the memory in the accept
//  cycle, then the result is shown for one cycle while busy is high. Status
//  and popped value come from registers and the registered memory read
//  port. No new beat is accepted while busy is high.
//  Reset: rst_n synchronous active low; stacks empty, capacity = STORE_DEPTH.
//  Memory content is not cleared; no clearing pass.
//  Stalls: the receiver cannot stall; results are never held.
// ---------------------------------------------------------------------------

module dual_stack_shared_store #(
  parameter int STORE_DEPTH = dss_pkg::DEF_STORE_DEPTH,
  parameter int VALUE_WIDTH = dss_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // command beat
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_action,
  input  logic                                  in_stack_select,
  input  logic signed [dss_pkg::IN_VALUE_W-1:0] in_push_value,
  // result beat
  output logic                                  out_strobe,
  output logic        [dss_pkg::STATUS_W-1:0]   out_status,
  output logic signed [dss_pkg::IN_VALUE_W-1:0] out_popped_value,
  output logic        [dss_pkg::DEPTH_W-1:0]    out_depth_lower,
  output logic        [dss_pkg::DEPTH_W-1:0]    out_depth_upper,
  // capacity register
  input  logic                                  cfg_we,
  input  logic        [dss_pkg::CFG_W-1:0]      cfg_wdata
);
  import dss_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: gates accept on busy, pulses exec, frames the result cycle,
  // and lets a capacity write through only when both stacks are empty.
  dss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .cfg_we     (cfg_we),
    .stat       (stat),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  // Datapath: pointers, full/empty tests, slot address, memory port and
  // result registers. Popped value reads zero unless a pop succeeded.
  dss_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_action        (in_action),
    .in_stack_select  (in_stack_select),
    .in_push_value    (in_push_value),
    .cfg_wdata        (cfg_wdata),
    .stat             (stat),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_depth_lower  (out_depth_lower),
    .out_depth_upper  (out_depth_upper)
  );

endmodule
